### rtl/core/http_chunked_body_decoder_top_defines.svh
// Assertion helpers shared by the decoder RTL.
// Both forms sample on the rising edge of clk and stay quiet while rst is high.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LENGTH_W = 32;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Configuration register indexes.
  localparam logic [0:0] CFG_MAX_BODY_SIZE = 1'b0;
  localparam logic [0:0] CFG_DISCARD_BODY  = 1'b1;

  localparam logic [LENGTH_W-1:0] MAX_BODY_SIZE_RESET = 32'd1048576;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_SIZE      = 4'd1,
    PH_SIZE_CR   = 4'd2,
    PH_DATA      = 4'd3,
    PH_AFTER     = 4'd4,
    PH_AFTER_CR  = 4'd5,
    PH_LAST_CR   = 4'd6,
    PH_LAST_LINE = 4'd7,
    PH_END_CR    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_BAD      = 2'd2,
    ST_TOOLARGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] max_body_size;
    logic                discard_body;
  } cfg_t;

  typedef struct packed {
    logic                data_valid;
    logic [BYTE_W-1:0]   body_byte;
    status_t             status;
    logic [LENGTH_W-1:0] body_length;
  } result_t;

  // Hex digit value 0..15, or 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] low;
    low = ch | 8'h20;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      return 5'(ch - 8'h30);
    end else if (low >= 8'h61 && low <= 8'h66) begin
      return 5'(low - 8'h57);
    end
    return 5'd16;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hcbd_parser.sv
`default_nettype none

`include "http_chunked_body_decoder_top_defines.svh"

module hcbd_parser import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              new_message,
  input  wire cfg_t              cfg,
  output result_t                result
);

  localparam int unsigned SUM_W = ((SIZE_BITS > LENGTH_W) ? SIZE_BITS : LENGTH_W) + 1;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  chunk_target, chunk_target_next;
  logic [SIZE_BITS-1:0]  chunk_count, chunk_count_next;
  logic [LENGTH_W-1:0]   total_length, total_length_next;
  status_t               sticky_status, sticky_status_next;

  phase_t                ph;
  logic [SIZE_BITS-1:0]  tgt;
  logic [SIZE_BITS-1:0]  cnt;
  logic [SIZE_BITS-1:0]  cnt_inc;
  logic [LENGTH_W-1:0]   tot;
  status_t               st;
  logic [4:0]            hv;
  logic                  is_hex;
  logic                  over_limit;
  logic                  emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      chunk_target  <= '0;
      chunk_count   <= '0;
      total_length  <= '0;
      sticky_status <= ST_BUSY;
    end else if (adv) begin
      phase         <= phase_next;
      chunk_target  <= chunk_target_next;
      chunk_count   <= chunk_count_next;
      total_length  <= total_length_next;
      sticky_status <= sticky_status_next;
    end
  end

  always_comb begin
    // A new message clears the parser before its first byte is looked at.
    ph  = new_message ? PH_START : phase;
    tgt = new_message ? '0 : chunk_target;
    cnt = new_message ? '0 : chunk_count;
    tot = new_message ? '0 : total_length;
    st  = new_message ? ST_BUSY : sticky_status;

    hv         = hex_value(data_byte);
    is_hex     = !hv[4];
    cnt_inc    = cnt + SIZE_BITS'(1);
    over_limit = (SUM_W'(tot) + SUM_W'(tgt)) > SUM_W'(cfg.max_body_size);

    phase_next         = ph;
    chunk_target_next  = tgt;
    chunk_count_next   = cnt;
    total_length_next  = tot;
    sticky_status_next = st;
    emit               = 1'b0;

    if (st == ST_BUSY) begin
      unique case (ph)
        PH_START: begin
          if (is_hex) begin
            chunk_target_next = SIZE_BITS'(hv[3:0]);
            phase_next        = PH_SIZE;
          end else begin
            sticky_status_next = ST_BAD;
          end
        end
        PH_SIZE: begin
          if (is_hex) begin
            if (tgt[SIZE_BITS-1 -: 4] != 4'd0) begin
              sticky_status_next = ST_BAD;
            end else begin
              chunk_target_next = {tgt[SIZE_BITS-5:0], hv[3:0]};
            end
          end else if (tgt == '0) begin
            if (data_byte == CH_CR) begin
              phase_next = PH_LAST_CR;
            end else if (data_byte == CH_LF) begin
              phase_next = PH_LAST_LINE;
            end else begin
              sticky_status_next = ST_BAD;
            end
          end else if (data_byte == CH_CR) begin
            phase_next = PH_SIZE_CR;
          end else if (data_byte == CH_LF) begin
            if (over_limit) begin
              sticky_status_next = ST_TOOLARGE;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            sticky_status_next = ST_BAD;
          end
        end
        PH_SIZE_CR: begin
          if (data_byte != CH_LF) begin
            sticky_status_next = ST_BAD;
          end else if (over_limit) begin
            sticky_status_next = ST_TOOLARGE;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          emit              = !cfg.discard_body;
          total_length_next = tot + LENGTH_W'(1);
          if (cnt_inc >= tgt) begin
            phase_next        = PH_AFTER;
            chunk_target_next = '0;
            chunk_count_next  = '0;
          end else begin
            chunk_count_next = cnt_inc;
          end
        end
        PH_AFTER: begin
          if (data_byte == CH_CR) begin
            phase_next = PH_AFTER_CR;
          end else if (data_byte == CH_LF) begin
            phase_next = PH_START;
          end else begin
            sticky_status_next = ST_BAD;
          end
        end
        PH_AFTER_CR: begin
          if (data_byte == CH_LF) begin
            phase_next = PH_START;
          end else begin
            sticky_status_next = ST_BAD;
          end
        end
        PH_LAST_CR: begin
          if (data_byte == CH_LF) begin
            phase_next = PH_LAST_LINE;
          end else begin
            sticky_status_next = ST_BAD;
          end
        end
        PH_LAST_LINE: begin
          if (data_byte == CH_CR) begin
            phase_next = PH_END_CR;
          end else if (data_byte == CH_LF) begin
            sticky_status_next = ST_DONE;
          end else begin
            sticky_status_next = ST_BAD;
          end
        end
        PH_END_CR: begin
          sticky_status_next = (data_byte == CH_LF) ? ST_DONE : ST_BAD;
        end
        default: begin
          sticky_status_next = ST_BAD;
        end
      endcase
    end

    result.data_valid  = emit;
    result.body_byte   = emit ? data_byte : '0;
    result.status      = sticky_status_next;
    result.body_length = total_length_next;
  end

  `HCBD_ASSERT_IMP(a_emit_in_data, adv && emit, ph == PH_DATA && st == ST_BUSY, "data emitted outside a chunk")
  `HCBD_ASSERT_IMP(a_count_below_target, phase == PH_DATA && sticky_status == ST_BUSY, chunk_count < chunk_target, "chunk count reached target inside data phase")
  `HCBD_ASSERT_NEXT(a_sticky_holds, adv && !new_message && sticky_status != ST_BUSY, $stable(phase) && $stable(total_length) && $stable(sticky_status), "parser state moved after the message ended")

endmodule

`default_nettype wire

### rtl/core/hcbd_out_stage.sv
`default_nettype none

module hcbd_out_stage import hcbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire result_t              result,
  output logic                      full,
  output logic                      free,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic                      m_tuser
);

  result_t held;

  // The stage can take a new word when empty or when its word leaves this cycle.
  assign free = !full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= result;
    end
  end

  assign m_tuser = held.data_valid;
  assign m_tdata = {6'd0, held.body_length, held.status, held.body_byte};

endmodule

`default_nettype wire

### rtl/core/http_chunked_body_decoder_top.sv
`default_nettype none

// Chunked HTTP body decoder. Raw body bytes enter on the s_ side with
// s_tuser set on the first byte of a new message; every byte gives exactly
// one word on the m_ side carrying the emitted data byte (m_tuser high when
// it is real body data), the message status and the running body length.
// One byte is taken per clock while m_tready is high: the byte sits in an
// input register, then the parser updates its state and loads the output
// register in the same cycle once the output stage is free; throughput is
// one word a cycle under that condition. Configuration may be written only
// while no word is in flight.
module http_chunked_body_decoder_top import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  wire logic                 s_tuser,   // [0] new_message
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // [7:0] body_byte, [9:8] status,
                                               // [41:10] body_length, rest zero
  output logic                      m_tuser,   // [0] data_valid
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [LENGTH_W-1:0]  cfg_data
);

  cfg_t              cfg;
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              in_new;
  logic              out_free;
  logic              adv;
  result_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_body_size <= MAX_BODY_SIZE_RESET;
      cfg.discard_body  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BODY_SIZE: cfg.max_body_size <= cfg_data;
        CFG_DISCARD_BODY:  cfg.discard_body  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv      = in_full && out_free;
  assign s_tready = !in_full || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[BYTE_W-1:0];
      in_new  <= s_tuser;
    end
  end

  hcbd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .data_byte   (in_byte),
    .new_message (in_new),
    .cfg         (cfg),
    .result      (result)
  );

  hcbd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (adv),
    .result   (result),
    .full     (m_tvalid),
    .free     (out_free),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### tb/hcbd_body_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the register port of the chunked body decoder,
// keeps its own copy of the parser state and compares every output word
// with the word predicted for the oldest accepted input byte.
module hcbd_body_checker import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                 s_tuser,   // [0] new_message
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] body_byte, [9:8] status,
                                          // [41:10] body_length, rest zero
  input  logic                 m_tuser,   // [0] data_valid
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [LENGTH_W-1:0]  cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   bytes_in,
  output int                   words_out,
  output int                   ends_done,
  output int                   ends_bad,
  output int                   ends_big,
  output int                   bytes_emitted
);

  logic [LENGTH_W-1:0]  limit_bytes;
  logic                 discard;

  phase_t               phase;
  logic [SIZE_BITS-1:0] chunk_size;
  logic [SIZE_BITS-1:0] chunk_seen;
  logic [LENGTH_W-1:0]  body_total;
  status_t              msg_status;

  result_t              words_due[$];

  task automatic start_message();
    phase      = PH_START;
    chunk_size = '0;
    chunk_seen = '0;
    body_total = '0;
    msg_status = ST_BUSY;
  endtask

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'("0") && c <= 8'("9")) return 5'(c - 8'("0"));
    if (c >= 8'("a") && c <= 8'("f")) return 5'(c - 8'("a") + 8'd10);
    if (c >= 8'("A") && c <= 8'("F")) return 5'(c - 8'("A") + 8'd10);
    return 5'd16;
  endfunction

  // A nonzero size line has ended: the whole body must still fit the limit.
  task automatic close_size_line();
    if ({1'b0, body_total} + (LENGTH_W + 1)'(chunk_size) > {1'b0, limit_bytes}) begin
      msg_status = ST_TOOLARGE;
    end else begin
      phase = PH_DATA;
    end
  endtask

  task automatic decode_byte(input logic [7:0] ch, input logic restart, output result_t word);
    logic [4:0] digit;
    logic       emit;
    status_t    was;
    emit = 1'b0;
    if (restart) start_message();
    was = msg_status;
    if (msg_status == ST_BUSY) begin
      digit = nibble_of(ch);
      case (phase)
        PH_START: begin
          if (!digit[4]) begin
            chunk_size = SIZE_BITS'(digit);
            phase = PH_SIZE;
          end else begin
            msg_status = ST_BAD;
          end
        end
        PH_SIZE: begin
          if (!digit[4]) begin
            // One more digit would push the size past SIZE_BITS bits.
            if (chunk_size[SIZE_BITS-1 -: 4] != 4'd0) msg_status = ST_BAD;
            else chunk_size = {chunk_size[SIZE_BITS-5:0], digit[3:0]};
          end else if (chunk_size == '0) begin
            if (ch == CH_CR) phase = PH_LAST_CR;
            else if (ch == CH_LF) phase = PH_LAST_LINE;
            else msg_status = ST_BAD;
          end else if (ch == CH_CR) begin
            phase = PH_SIZE_CR;
          end else if (ch == CH_LF) begin
            close_size_line();
          end else begin
            msg_status = ST_BAD;
          end
        end
        PH_SIZE_CR: begin
          if (ch == CH_LF) close_size_line();
          else msg_status = ST_BAD;
        end
        PH_DATA: begin
          emit = !discard;
          body_total = body_total + 1'b1;
          chunk_seen = chunk_seen + 1'b1;
          if (chunk_seen >= chunk_size) begin
            phase = PH_AFTER;
            chunk_size = '0;
            chunk_seen = '0;
          end
        end
        PH_AFTER: begin
          if (ch == CH_CR) phase = PH_AFTER_CR;
          else if (ch == CH_LF) phase = PH_START;
          else msg_status = ST_BAD;
        end
        PH_AFTER_CR: begin
          if (ch == CH_LF) phase = PH_START;
          else msg_status = ST_BAD;
        end
        PH_LAST_CR: begin
          if (ch == CH_LF) phase = PH_LAST_LINE;
          else msg_status = ST_BAD;
        end
        PH_LAST_LINE: begin
          if (ch == CH_CR) phase = PH_END_CR;
          else if (ch == CH_LF) msg_status = ST_DONE;
          else msg_status = ST_BAD;
        end
        PH_END_CR: begin
          msg_status = (ch == CH_LF) ? ST_DONE : ST_BAD;
        end
        default: begin
          msg_status = ST_BAD;
        end
      endcase
    end
    if (was == ST_BUSY) begin
      case (msg_status)
        ST_DONE:     ends_done++;
        ST_BAD:      ends_bad++;
        ST_TOOLARGE: ends_big++;
        default: ;
      endcase
    end
    if (emit) bytes_emitted++;
    word.data_valid  = emit;
    word.body_byte   = emit ? ch : 8'd0;
    word.status      = msg_status;
    word.body_length = body_total;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t next_word;
    if (rst) begin
      limit_bytes = MAX_BODY_SIZE_RESET;
      discard = 1'b0;
      start_message();
      words_due.delete();
      fail_count = 0;
      bytes_in = 0;
      words_out = 0;
      ends_done = 0;
      ends_bad = 0;
      ends_big = 0;
      bytes_emitted = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_BODY_SIZE) limit_bytes = cfg_data;
        else if (cfg_index == CFG_DISCARD_BODY) discard = cfg_data[0];
      end
      if (m_tvalid && m_tready) begin
        words_out++;
        if (words_due.size() == 0) begin
          $error("output word %0h arrived with no byte waiting for it", m_tdata);
          fail_count++;
        end else begin
          want = words_due.pop_front();
          check_field("data_valid", 32'(want.data_valid), 32'(m_tuser));
          check_field("body_byte", 32'(want.body_byte), 32'(m_tdata[7:0]));
          check_field("status", 32'(want.status), 32'(m_tdata[9:8]));
          check_field("body_length", want.body_length, m_tdata[41:10]);
          check_field("tdata padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:42]));
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_in++;
        decode_byte(s_tdata[7:0], s_tuser, next_word);
        words_due.push_back(next_word);
      end
    end
    pending <= words_due.size();
  end

endmodule

### tb/tb_http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_top import hcbd_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;    // [7:0] data_byte
  logic                 s_tuser = 1'b0;  // [0] new_message
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // [7:0] body_byte, [9:8] status,
                                         // [41:10] body_length, rest zero
  logic                 m_tuser;         // [0] data_valid
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = '0;
  logic [LENGTH_W-1:0]  cfg_data = '0;

  int  fail_count, pending, bytes_in, words_out;
  int  ends_done, ends_bad, ends_big, bytes_emitted;

  int  n_sent = 0;
  int  stall_cycles = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  logic [7:0] msg_q[$];

  http_chunked_body_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hcbd_body_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_in      (bytes_in),
    .words_out     (words_out),
    .ends_done     (ends_done),
    .ends_bad      (ends_bad),
    .ends_big      (ends_big),
    .bytes_emitted (bytes_emitted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: short random stalls, and one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one word and returns at the edge where it was taken.
  task automatic put(input logic [7:0] b, input logic restart);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [LENGTH_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [LENGTH_W-1:0] limit, input logic discard);
    drain();
    write_reg(CFG_MAX_BODY_SIZE, limit);
    write_reg(CFG_DISCARD_BODY, LENGTH_W'(discard));
  endtask

  task automatic push_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      msg_q.push_back(8'("0") + 8'(d));
    end else begin
      msg_q.push_back(($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(d) - 8'd10);
    end
  endtask

  task automatic push_hex(input logic [31:0] v);
    int msd;
    repeat ($urandom_range(0, 2)) msg_q.push_back(8'("0"));
    msd = 7;
    while (msd > 0 && v[msd*4 +: 4] == 4'd0) msd--;
    for (int i = msd; i >= 0; i--) push_digit(v[i*4 +: 4]);
  endtask

  task automatic push_eol(input bit crlf);
    if (crlf) msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
  endtask

  task automatic send_msg(input logic restart);
    foreach (msg_q[i]) put(msg_q[i], (i == 0) ? restart : 1'b0);
  endtask

  // Mostly well-formed bodies with random content; some carry a broken byte,
  // are cut short, or have a size with too many digits.
  task automatic gen_message();
    int pick, len, cut;
    msg_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      push_digit(4'($urandom_range(1, 15)));
      repeat ($urandom_range(8, 9)) push_digit(4'($urandom_range(0, 15)));
      push_eol($urandom_range(0, 1));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
        push_hex(len);
        push_eol($urandom_range(0, 1));
        repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
        push_eol($urandom_range(0, 1));
      end
      push_hex(0);
      push_eol($urandom_range(0, 1));
      push_eol($urandom_range(0, 1));
      if (pick < 16) begin
        msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 22) begin
        cut = $urandom_range(1, msg_q.size() - 1);
        while (msg_q.size() > cut) void'(msg_q.pop_back());
      end
    end
  endtask

  task automatic run_random(input int quota);
    int stop;
    stop = n_sent + quota;
    while (n_sent < stop) begin
      if (!quiet) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        gen_message();
        send_msg($urandom_range(0, 9) != 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_reg(CFG_MAX_BODY_SIZE, MAX_BODY_SIZE_RESET);
    write_reg(CFG_DISCARD_BODY, '0);

    // Data bytes at both extremes, bare LF after the data, zero size on a
    // bare LF, CR LF to finish; then a byte after completion is ignored.
    msg_q = '{8'("2"), CH_CR, CH_LF, 8'h00, 8'hFF, CH_LF, 8'("0"), CH_LF, CH_CR, CH_LF};
    send_msg(1'b1);
    put(8'("G"), 1'b0);
    // Zero size on CR LF, body closed by a bare LF.
    msg_q = '{8'("0"), CH_CR, CH_LF, CH_LF};
    send_msg(1'b1);
    // Nine size digits overflow the size register.
    msg_q = '{8'("f"), 8'("F"), 8'("f"), 8'("F"), 8'("f"), 8'("F"), 8'("f"), 8'("F"),
              8'("f")};
    send_msg(1'b1);
    // Mixed-case size far beyond the default limit.
    msg_q = '{8'("a"), 8'("B"), 8'("c"), 8'("D"), 8'("e"), 8'("F"), 8'("0"), 8'("1"), CH_LF};
    send_msg(1'b1);
    // Chunk extensions are not supported.
    msg_q = '{8'("1"), 8'(";")};
    send_msg(1'b1);

    set_config('0, 1'b0);
    run_random(100);
    set_config('1, 1'b1);
    run_random(220);

    // Output held off while input keeps coming, then a full pause.
    hold_req = 1'b1;
    run_random(60);
    drain();

    set_config(LENGTH_W'($urandom_range(16, 80)), 1'b0);
    run_random(260);

    quiet = 1'b1;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_config(MAX_BODY_SIZE_RESET, 1'b0);
    run_random(280);

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes and checked %0d words across five limit and discard settings.",
             bytes_in, words_out);
    $display("Bodies ended complete %0d, malformed %0d, over limit %0d; %0d data bytes passed.",
             ends_done, ends_bad, ends_big, bytes_emitted);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_parser.sv
rtl/core/hcbd_out_stage.sv
rtl/core/http_chunked_body_decoder_top.sv
tb/hcbd_body_checker.sv
tb/tb_http_chunked_body_decoder_top.sv
